[rtl/fcs_pkg.sv]
// ----------------------------------------------------------------------------
// Fair credit semaphore package
// Shared constants, codes, types and the saturation helper of the block.
// ----------------------------------------------------------------------------
package fcs_pkg;

  localparam int IdPortW        = 8;
  localparam int CountW         = 16;
  localparam int FreeW          = 18;
  localparam int MaxResults     = 16;
  localparam int CntW           = 5;
  localparam int DefQueueDepth  = 16;
  localparam int DefIdBits      = 8;

  localparam logic signed [FreeW:0] FreeMin = -19'sd65536;
  localparam logic signed [FreeW:0] FreeMax = 19'sd131071;

  typedef enum logic [1:0] {
    REQ_ACQUIRE = 2'd0,
    REQ_RELEASE = 2'd1,
    REQ_TICK    = 2'd2,
    REQ_NONE    = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    EV_STATUS  = 2'd0,
    EV_GRANT   = 2'd1,
    EV_TIMEOUT = 2'd2,
    EV_REJECT  = 2'd3
  } event_kind_e;

  typedef struct packed {
    logic                     push;
    logic                     finish;
    event_kind_e              kind;
    logic [IdPortW-1:0]       who;
    logic signed [FreeW-1:0]  free;
  } fcs_evt_t;

  typedef struct packed {
    logic push_ok;
    logic fin_ok;
  } fcs_ostat_t;

  function automatic logic signed [FreeW-1:0] fcs_clamp(input logic signed [FreeW:0] v);
    logic signed [FreeW-1:0] r;
    if (v < FreeMin) begin
      r = FreeMin[FreeW-1:0];
    end else if (v > FreeMax) begin
      r = FreeMax[FreeW-1:0];
    end else begin
      r = v[FreeW-1:0];
    end
    return r;
  endfunction

endpackage

[rtl/fcs_ram.sv]
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module fcs_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/fcs_out_stage.sv]
// ----------------------------------------------------------------------------
// Result output stage
// Holds the latest event until the next one shows whether it is the final
// one, and drives the registered result channel.
// ----------------------------------------------------------------------------
module fcs_out_stage #(
  parameter int QUEUE_DEPTH = fcs_pkg::DefQueueDepth
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  fcs_pkg::fcs_evt_t                       evt_i,
  input  logic [$clog2(QUEUE_DEPTH+1)-1:0]        wcount_i,
  output fcs_pkg::fcs_ostat_t                     ostat_o,
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic [1:0]                              event_kind_o,
  output logic [fcs_pkg::IdPortW-1:0]             event_requester_o,
  output logic signed [fcs_pkg::FreeW-1:0]        free_credits_o,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]        waiting_count_o,
  output logic                                    last_o
);

  localparam int LenW = $clog2(QUEUE_DEPTH + 1);

  logic                             pend_v_q, pend_v_d;
  fcs_pkg::event_kind_e             pend_kind_q;
  logic [fcs_pkg::IdPortW-1:0]      pend_who_q;
  logic signed [fcs_pkg::FreeW-1:0] pend_free_q;
  logic [LenW-1:0]                  pend_wc_q;

  logic                             out_v_q, out_v_d;
  fcs_pkg::event_kind_e             out_kind_q;
  logic [fcs_pkg::IdPortW-1:0]      out_who_q;
  logic signed [fcs_pkg::FreeW-1:0] out_free_q;
  logic [LenW-1:0]                  out_wc_q;
  logic                             out_last_q;

  logic out_room;
  logic do_push;
  logic do_fin;
  logic load_out;

  assign out_room        = !out_v_q || !out_stall_i;
  assign ostat_o.push_ok = !pend_v_q || out_room;
  assign ostat_o.fin_ok  = out_room;
  assign do_push         = evt_i.push;
  assign do_fin          = evt_i.finish && out_room;
  assign load_out        = do_fin || (do_push && pend_v_q);

  always_comb begin
    pend_v_d = pend_v_q;
    if (do_fin) begin
      pend_v_d = 1'b0;
    end else if (do_push) begin
      pend_v_d = 1'b1;
    end
    out_v_d = out_v_q && out_stall_i;
    if (load_out) begin
      out_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      if (do_fin && !pend_v_q) begin
        out_kind_q <= evt_i.kind;
        out_who_q  <= evt_i.who;
        out_free_q <= evt_i.free;
        out_wc_q   <= wcount_i;
      end else begin
        out_kind_q <= pend_kind_q;
        out_who_q  <= pend_who_q;
        out_free_q <= pend_free_q;
        out_wc_q   <= pend_wc_q;
      end
      out_last_q <= do_fin;
    end
    if (do_push) begin
      pend_kind_q <= evt_i.kind;
      pend_who_q  <= evt_i.who;
      pend_free_q <= evt_i.free;
      pend_wc_q   <= wcount_i;
    end
  end

  assign out_valid_o       = out_v_q;
  assign event_kind_o      = out_kind_q;
  assign event_requester_o = out_who_q;
  assign free_credits_o    = out_free_q;
  assign waiting_count_o   = out_wc_q;
  assign last_o            = out_last_q;

endmodule

[rtl/fcs_ctrl.sv]
// ----------------------------------------------------------------------------
// Semaphore queue controller
// Keeps the credit pool and the circular waiter queue, runs the grant passes
// and the aging and expiry sweep over the queue memory.
// ----------------------------------------------------------------------------
module fcs_ctrl #(
  parameter int QUEUE_DEPTH = fcs_pkg::DefQueueDepth,
  parameter int ID_BITS     = fcs_pkg::DefIdBits,
  parameter int ENT_W       = 40
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [fcs_pkg::CountW-1:0]          total_permits_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          req_type_i,
  input  logic [fcs_pkg::IdPortW-1:0]         requester_id_i,
  input  logic [fcs_pkg::CountW-1:0]          permit_count_i,
  input  logic [fcs_pkg::CountW-1:0]          timeout_ticks_i,
  output logic                                ram_we_o,
  output logic [$clog2(QUEUE_DEPTH)-1:0]      ram_waddr_o,
  output logic [ENT_W-1:0]                    ram_wdata_o,
  output logic                                ram_re_o,
  output logic [$clog2(QUEUE_DEPTH)-1:0]      ram_raddr_o,
  input  logic [ENT_W-1:0]                    ram_rdata_i,
  output fcs_pkg::fcs_evt_t                   evt_o,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]    wcount_o,
  input  fcs_pkg::fcs_ostat_t                 ostat_i
);

  localparam int PtrW    = $clog2(QUEUE_DEPTH);
  localparam int LenW    = $clog2(QUEUE_DEPTH + 1);
  localparam int SumW    = PtrW + 1;
  localparam int IdW     = (ID_BITS < fcs_pkg::IdPortW) ? ID_BITS : fcs_pkg::IdPortW;
  localparam int IdPortW = fcs_pkg::IdPortW;
  localparam int CntW    = fcs_pkg::CntW;
  localparam int FreeW   = fcs_pkg::FreeW;
  localparam int CountW  = fcs_pkg::CountW;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GRD,
    ST_GCHK,
    ST_SRD,
    ST_SPR,
    ST_FIN
  } state_e;

  state_e                   state_q, state_d;
  logic [PtrW-1:0]          hd_q, hd_d;
  logic [LenW-1:0]          len_q, len_d;
  logic signed [FreeW-1:0]  free_q, free_d;
  logic [CountW-1:0]        total_q, total_d;
  logic [CntW-1:0]          cnt_q, cnt_d;
  logic                     tick_q, tick_d;
  logic                     second_q, second_d;
  logic [PtrW-1:0]          rp_q, rp_d;
  logic [PtrW-1:0]          wp_q, wp_d;
  logic [LenW-1:0]          left_q, left_d;

  logic                     accept;
  fcs_pkg::req_type_e       req;
  logic [SumW-1:0]          tail_sum;
  logic [PtrW-1:0]          tail;
  logic signed [FreeW:0]    cfg_sum;
  logic signed [FreeW-1:0]  free_cfg;
  logic signed [FreeW:0]    rel_sum;
  logic [IdW-1:0]           rd_id;
  logic [CountW-1:0]        rd_perm;
  logic [CountW-1:0]        rd_rem;
  logic [CountW-1:0]        rem_new;
  logic                     grant_ok;
  logic signed [FreeW-1:0]  free_gr;
  logic                     budget_full;
  logic                     expire;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] r;
    if (p == PtrW'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign req         = fcs_pkg::req_type_e'(req_type_i);

  assign tail_sum    = SumW'(hd_q) + SumW'(len_q);
  assign tail        = (tail_sum >= SumW'(QUEUE_DEPTH)) ?
                       PtrW'(tail_sum - SumW'(QUEUE_DEPTH)) : PtrW'(tail_sum);

  assign cfg_sum     = {free_q[FreeW-1], free_q} + $signed({3'b000, total_permits_i})
                       - $signed({3'b000, total_q});
  assign free_cfg    = cfg_we_i ? fcs_pkg::fcs_clamp(cfg_sum) : free_q;
  assign rel_sum     = {free_cfg[FreeW-1], free_cfg} + $signed({3'b000, permit_count_i});

  assign rd_id       = ram_rdata_i[ENT_W-1 -: IdW];
  assign rd_perm     = ram_rdata_i[2*CountW-1:CountW];
  assign rd_rem      = ram_rdata_i[CountW-1:0];
  assign rem_new     = (tick_q && rd_rem != '0) ? rd_rem - 1'b1 : rd_rem;

  assign grant_ok    = free_q >= $signed({2'b00, rd_perm});
  assign free_gr     = free_q - $signed({2'b00, rd_perm});
  assign budget_full = (cnt_q == CntW'(fcs_pkg::MaxResults));
  assign expire      = (rem_new == '0) && !budget_full;

  always_comb begin
    state_d     = state_q;
    hd_d        = hd_q;
    len_d       = len_q;
    free_d      = free_q;
    total_d     = total_q;
    cnt_d       = cnt_q;
    tick_d      = tick_q;
    second_d    = second_q;
    rp_d        = rp_q;
    wp_d        = wp_q;
    left_d      = left_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = wp_q;
    ram_wdata_o = {rd_id, rd_perm, rem_new};
    ram_re_o    = 1'b0;
    ram_raddr_o = hd_q;
    evt_o       = '0;
    evt_o.free  = free_q;
    wcount_o    = len_q;

    unique case (state_q)
      ST_IDLE: begin
        if (cfg_we_i) begin
          free_d  = free_cfg;
          total_d = total_permits_i;
        end
        if (accept) begin
          cnt_d    = '0;
          tick_d   = (req == fcs_pkg::REQ_TICK);
          second_d = 1'b0;
          state_d  = ST_GRD;
          unique case (req)
            fcs_pkg::REQ_ACQUIRE: begin
              if (len_q == LenW'(QUEUE_DEPTH)) begin
                evt_o.push = 1'b1;
                evt_o.kind = fcs_pkg::EV_REJECT;
                evt_o.who  = IdPortW'(requester_id_i[IdW-1:0]);
                cnt_d      = CntW'(1);
              end else begin
                ram_we_o    = 1'b1;
                ram_waddr_o = tail;
                ram_wdata_o = {requester_id_i[IdW-1:0], permit_count_i, timeout_ticks_i};
                len_d       = len_q + 1'b1;
              end
            end
            fcs_pkg::REQ_RELEASE: begin
              free_d = fcs_pkg::fcs_clamp(rel_sum);
            end
            fcs_pkg::REQ_TICK: begin
            end
            fcs_pkg::REQ_NONE: begin
            end
          endcase
        end
      end

      ST_GRD: begin
        if (len_q == '0 || budget_full) begin
          if (second_q) begin
            state_d = ST_FIN;
          end else begin
            rp_d    = hd_q;
            wp_d    = hd_q;
            left_d  = len_q;
            state_d = ST_SRD;
          end
        end else begin
          ram_re_o    = 1'b1;
          ram_raddr_o = hd_q;
          state_d     = ST_GCHK;
        end
      end

      ST_GCHK: begin
        if (grant_ok) begin
          if (ostat_i.push_ok) begin
            evt_o.push = 1'b1;
            evt_o.kind = fcs_pkg::EV_GRANT;
            evt_o.who  = IdPortW'(rd_id);
            evt_o.free = free_gr;
            wcount_o   = len_q - 1'b1;
            free_d     = free_gr;
            hd_d       = ptr_inc(hd_q);
            len_d      = len_q - 1'b1;
            cnt_d      = cnt_q + 1'b1;
            state_d    = ST_GRD;
          end
        end else if (second_q) begin
          state_d = ST_FIN;
        end else begin
          rp_d    = hd_q;
          wp_d    = hd_q;
          left_d  = len_q;
          state_d = ST_SRD;
        end
      end

      ST_SRD: begin
        if (left_q == '0) begin
          second_d = 1'b1;
          state_d  = ST_GRD;
        end else begin
          ram_re_o    = 1'b1;
          ram_raddr_o = rp_q;
          state_d     = ST_SPR;
        end
      end

      ST_SPR: begin
        if (expire) begin
          if (ostat_i.push_ok) begin
            evt_o.push = 1'b1;
            evt_o.kind = fcs_pkg::EV_TIMEOUT;
            evt_o.who  = IdPortW'(rd_id);
            wcount_o   = len_q - 1'b1;
            len_d      = len_q - 1'b1;
            cnt_d      = cnt_q + 1'b1;
            rp_d       = ptr_inc(rp_q);
            left_d     = left_q - 1'b1;
            state_d    = ST_SRD;
          end
        end else begin
          ram_we_o    = 1'b1;
          ram_waddr_o = wp_q;
          wp_d        = ptr_inc(wp_q);
          rp_d        = ptr_inc(rp_q);
          left_d      = left_q - 1'b1;
          state_d     = ST_SRD;
        end
      end

      ST_FIN: begin
        evt_o.finish = ostat_i.fin_ok;
        evt_o.kind   = fcs_pkg::EV_STATUS;
        if (ostat_i.fin_ok) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      hd_q     <= '0;
      len_q    <= '0;
      free_q   <= '0;
      total_q  <= '0;
      cnt_q    <= '0;
      tick_q   <= 1'b0;
      second_q <= 1'b0;
      rp_q     <= '0;
      wp_q     <= '0;
      left_q   <= '0;
    end else begin
      state_q  <= state_d;
      hd_q     <= hd_d;
      len_q    <= len_d;
      free_q   <= free_d;
      total_q  <= total_d;
      cnt_q    <= cnt_d;
      tick_q   <= tick_d;
      second_q <= second_d;
      rp_q     <= rp_d;
      wp_q     <= wp_d;
      left_q   <= left_d;
    end
  end

endmodule

[rtl/fair_fifo_credit_semaphore_top.sv]
// ----------------------------------------------------------------------------
// Fair FIFO credit semaphore
// Counting semaphore with a first-in first-out queue of waiters and timeouts.
// ----------------------------------------------------------------------------
// One transaction at a time is processed. An acquire enters the tail of a
// circular queue held in one synchronous RAM, or is rejected if the queue is
// full, a release returns credits, and a tick ages the waiters. Every
// transaction then grants head waiters while the free credits cover them,
// sweeps the queue once to remove expired waiters (aging them on a tick), and
// grants again, reporting each event as one result with the final result of
// the transaction marked by last_o. Each entry visited by the sweep is read,
// updated and written back in turn.
// The input stall is raised from acceptance until the final result has been
// handed to the output register.
// ----------------------------------------------------------------------------
module fair_fifo_credit_semaphore_top #(
  parameter int QUEUE_DEPTH = fcs_pkg::DefQueueDepth,
  parameter int ID_BITS     = fcs_pkg::DefIdBits
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [fcs_pkg::CountW-1:0]            total_permits_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [1:0]                            req_type_i,
  input  logic [fcs_pkg::IdPortW-1:0]           requester_id_i,
  input  logic [fcs_pkg::CountW-1:0]            permit_count_i,
  input  logic [fcs_pkg::CountW-1:0]            timeout_ticks_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [1:0]                            event_kind_o,
  output logic [fcs_pkg::IdPortW-1:0]           event_requester_o,
  output logic signed [fcs_pkg::FreeW-1:0]      free_credits_o,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]      waiting_count_o,
  output logic                                  last_o
);

  localparam int PtrW  = $clog2(QUEUE_DEPTH);
  localparam int LenW  = $clog2(QUEUE_DEPTH + 1);
  localparam int IdW   = (ID_BITS < fcs_pkg::IdPortW) ? ID_BITS : fcs_pkg::IdPortW;
  localparam int EntW  = IdW + 2 * fcs_pkg::CountW;

  logic                 ram_we;
  logic [PtrW-1:0]      ram_waddr;
  logic [EntW-1:0]      ram_wdata;
  logic                 ram_re;
  logic [PtrW-1:0]      ram_raddr;
  logic [EntW-1:0]      ram_rdata;
  fcs_pkg::fcs_evt_t    evt;
  fcs_pkg::fcs_ostat_t  ostat;
  logic [LenW-1:0]      wcount;

  fcs_ram #(
    .WIDTH (EntW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  fcs_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_BITS     (ID_BITS),
    .ENT_W       (EntW)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .total_permits_i (total_permits_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .req_type_i      (req_type_i),
    .requester_id_i  (requester_id_i),
    .permit_count_i  (permit_count_i),
    .timeout_ticks_i (timeout_ticks_i),
    .ram_we_o        (ram_we),
    .ram_waddr_o     (ram_waddr),
    .ram_wdata_o     (ram_wdata),
    .ram_re_o        (ram_re),
    .ram_raddr_o     (ram_raddr),
    .ram_rdata_i     (ram_rdata),
    .evt_o           (evt),
    .wcount_o        (wcount),
    .ostat_i         (ostat)
  );

  fcs_out_stage #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_out_stage (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .evt_i             (evt),
    .wcount_i          (wcount),
    .ostat_o           (ostat),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .event_kind_o      (event_kind_o),
    .event_requester_o (event_requester_o),
    .free_credits_o    (free_credits_o),
    .waiting_count_o   (waiting_count_o),
    .last_o            (last_o)
  );

endmodule
